### rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared widths and types for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int LEN_BITS    = 64;
    localparam int BYTE_W      = 8;
    localparam int OPCODE_W    = 4;
    localparam int KEY_W       = 32;
    localparam int EXT_CNT_W   = 3;
    localparam int MASK_IDX_W  = 2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [EXT_CNT_W-1:0] EXT16_COUNT = 3'd1;
    localparam logic [EXT_CNT_W-1:0] EXT64_COUNT = 3'd7;
    localparam logic [EXT_CNT_W-1:0] KEY_COUNT   = 3'd3;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [LEN_BITS-1:0] len_t;

    typedef struct packed {
        byte_t   payload_byte;
        logic    byte_valid;
        opcode_t message_opcode;
        logic    frame_end;
        logic    message_end;
    } wsd_result_t;

endpackage

### rtl/wsd_byte_if.sv
// ----------------------------------------------------------------------------
// wsd_byte_if
// Valid/ready channel carrying one received stream byte per item.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
    import wsd_pkg::*;

    logic  valid;
    logic  ready;
    byte_t byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### rtl/wsd_result_if.sv
// ----------------------------------------------------------------------------
// wsd_result_if
// Valid/ready channel carrying one deframed payload item.
// ----------------------------------------------------------------------------
interface wsd_result_if;
    import wsd_pkg::*;

    logic    valid;
    logic    ready;
    byte_t   payload_byte;
    logic    byte_valid;
    opcode_t message_opcode;
    logic    frame_end;
    logic    message_end;

    modport source (output valid, output payload_byte, output byte_valid,
                    output message_opcode, output frame_end, output message_end,
                    input ready);
    modport sink   (input valid, input payload_byte, input byte_valid,
                    input message_opcode, input frame_end, input message_end,
                    output ready);
endinterface

### rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Parses a WebSocket frame byte stream and emits unmasked payload items.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   byte_in
//  out_ch    out  payload_byte, byte_valid, message_opcode, frame_end,
//                 message_end
//
//  One byte per clock sustained while out_ch is not stalled; a byte's result
//  is registered twice (input register, then the parse logic into the output
//  register) before it is presented on out_ch.
//  The 64-bit length decrement and zero test set the path into the output.
//  rst_n clears all parser state to the header-byte-zero phase.
//  A stalled output holds the input register, which in turn holds in_ch.ready.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
    input  logic              clk,
    input  logic              rst_n,
    wsd_byte_if.sink          in_ch,
    wsd_result_if.source      out_ch
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic                   frame_fin_reg, frame_fin_next;
    opcode_t                frame_opcode_reg, frame_opcode_next;
    opcode_t                message_opcode_reg, message_opcode_next;
    logic                   in_message_reg, in_message_next;
    logic                   mask_present_reg, mask_present_next;
    logic [KEY_W-1:0]       mask_key_reg, mask_key_next;
    logic [EXT_CNT_W-1:0]   ext_count_reg, ext_count_next;
    len_t                   bytes_left_reg, bytes_left_next;
    logic [MASK_IDX_W-1:0]  mask_index_reg, mask_index_next;

    // output register
    logic        out_valid_reg;
    wsd_result_t out_reg;

    logic        advance;
    logic        res_fire;
    wsd_result_t res;

    logic [6:0]  len7;
    len_t        bytes_dec;
    byte_t       key_byte;
    logic        is_ctrl;
    logic        emit_end;

    // advance the parse stage only when the output slot is free or being taken
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    assign len7      = in_byte_reg[6:0];
    assign bytes_dec = bytes_left_reg - len_t'(1);
    assign is_ctrl   = frame_opcode_reg[OPCODE_W-1];

    always_comb
    begin
        case (mask_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
        if (!mask_present_reg)
        begin
            key_byte = '0;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        frame_fin_next      = frame_fin_reg;
        frame_opcode_next   = frame_opcode_reg;
        message_opcode_next = message_opcode_reg;
        in_message_next     = in_message_reg;
        mask_present_next   = mask_present_reg;
        mask_key_next       = mask_key_reg;
        ext_count_next      = ext_count_reg;
        bytes_left_next     = bytes_left_reg;
        mask_index_next     = mask_index_reg;
        res_fire            = 1'b0;
        emit_end            = 1'b0;
        res.payload_byte    = '0;
        res.byte_valid      = 1'b0;

        case (phase_reg)
            PH_HDR1:
            begin
                mask_present_next = in_byte_reg[7];
                mask_key_next     = '0;
                if (len7 == LEN7_EXT16)
                begin
                    bytes_left_next = '0;
                    ext_count_next  = EXT16_COUNT;
                    phase_next      = PH_EXT;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    bytes_left_next = '0;
                    ext_count_next  = EXT64_COUNT;
                    phase_next      = PH_EXT;
                end
                else
                begin
                    bytes_left_next = {{(LEN_BITS-7){1'b0}}, len7};
                    if (in_byte_reg[7])
                    begin
                        ext_count_next = KEY_COUNT;
                        phase_next     = PH_KEY;
                    end
                    else
                    begin
                        mask_index_next = '0;
                        if (len7 == 7'd0)
                        begin
                            res_fire = 1'b1;
                            emit_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_EXT:
            begin
                bytes_left_next = {bytes_left_reg[LEN_BITS-BYTE_W-1:0], in_byte_reg};
                if (ext_count_reg == '0)
                begin
                    if (mask_present_reg)
                    begin
                        ext_count_next = KEY_COUNT;
                        phase_next     = PH_KEY;
                    end
                    else
                    begin
                        mask_index_next = '0;
                        if (bytes_left_next == '0)
                        begin
                            res_fire = 1'b1;
                            emit_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                else
                begin
                    ext_count_next = ext_count_reg - EXT_CNT_W'(1);
                end
            end
            PH_KEY:
            begin
                mask_key_next = {mask_key_reg[KEY_W-BYTE_W-1:0], in_byte_reg};
                if (ext_count_reg == '0)
                begin
                    mask_index_next = '0;
                    if (bytes_left_reg == '0)
                    begin
                        res_fire = 1'b1;
                        emit_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    ext_count_next = ext_count_reg - EXT_CNT_W'(1);
                end
            end
            PH_DATA:
            begin
                mask_index_next  = mask_index_reg + MASK_IDX_W'(1);
                bytes_left_next  = bytes_dec;
                res_fire         = 1'b1;
                res.payload_byte = in_byte_reg ^ key_byte;
                res.byte_valid   = 1'b1;
                emit_end         = (bytes_dec == '0);
            end
            default:
            begin
                // header byte zero, also taken for unused phase codes
                frame_fin_next    = in_byte_reg[7];
                frame_opcode_next = in_byte_reg[OPCODE_W-1:0];
                if (!in_byte_reg[OPCODE_W-1] &&
                    (in_byte_reg[OPCODE_W-1:0] != '0 || !in_message_reg))
                begin
                    message_opcode_next = in_byte_reg[OPCODE_W-1:0];
                end
                phase_next = PH_HDR1;
            end
        endcase

        res.message_opcode = is_ctrl ? frame_opcode_reg : message_opcode_reg;
        res.frame_end      = emit_end;
        res.message_end    = emit_end & frame_fin_reg;

        // close the frame; data frames also update the open-message flag
        if (res_fire && emit_end)
        begin
            phase_next = PH_HDR0;
            if (!is_ctrl)
            begin
                in_message_next = !frame_fin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            in_byte_reg        <= '0;
            phase_reg          <= PH_HDR0;
            frame_fin_reg      <= 1'b0;
            frame_opcode_reg   <= '0;
            message_opcode_reg <= '0;
            in_message_reg     <= 1'b0;
            mask_present_reg   <= 1'b0;
            mask_key_reg       <= '0;
            ext_count_reg      <= '0;
            bytes_left_reg     <= '0;
            mask_index_reg     <= '0;
            out_valid_reg      <= 1'b0;
            out_reg            <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
                in_byte_reg  <= in_ch.byte_in;
            end

            if (advance)
            begin
                phase_reg          <= phase_next;
                frame_fin_reg      <= frame_fin_next;
                frame_opcode_reg   <= frame_opcode_next;
                message_opcode_reg <= message_opcode_next;
                in_message_reg     <= in_message_next;
                mask_present_reg   <= mask_present_next;
                mask_key_reg       <= mask_key_next;
                ext_count_reg      <= ext_count_next;
                bytes_left_reg     <= bytes_left_next;
                mask_index_reg     <= mask_index_next;
            end

            if (advance && res_fire)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.payload_byte   = out_reg.payload_byte;
    assign out_ch.byte_valid     = out_reg.byte_valid;
    assign out_ch.message_opcode = out_reg.message_opcode;
    assign out_ch.frame_end      = out_reg.frame_end;
    assign out_ch.message_end    = out_reg.message_end;

endmodule
